// File: hw/rtl/rpg_pkg.sv
// Shared types, widths and constants of the radar polar-to-grid pixel converter.
// Holds the CORDIC arctangent table and the stage structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rpg_pkg;

  // Sizing of the sweep and the grid
  localparam int RANGE_BINS     = 4096;
  localparam int AZIMUTH_COUNTS = 5600;
  localparam int MAX_GRID_DIM   = 4096;
  localparam int QUARTER_COUNTS = AZIMUTH_COUNTS / 4;

  // Field widths
  localparam int AZ_W   = 13;
  localparam int BIN_W  = 12;
  localparam int PIX_W  = 8;
  localparam int IDX_W  = 12;
  localparam int DIM_W  = 13;
  localparam int RES_W  = 24;
  localparam int ODD_W  = BIN_W + 1;
  localparam int QR_W   = $clog2(QUARTER_COUNTS);

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_GRID_ROWS = 2'd0;
  localparam logic [1:0] CFG_GRID_COLS = 2'd1;
  localparam logic [1:0] CFG_RES_Q16   = 2'd2;

  // Fixed-point constants
  localparam int ANGLE_STEP_Q30    = 1204736;
  localparam int HALF_BIN_STEP_Q32 = 94059784;
  localparam int CORDIC_GAIN_Q30   = 652032874;
  localparam int ROUND_SHIFT       = 15;

  // CORDIC datapath
  localparam int CW               = 34;
  localparam int CORDIC_STEPS     = 16;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
  localparam int TRIG_W           = 18;

  // Scaling and division datapath
  localparam int PROD_W    = ODD_W + 1 + TRIG_W;
  localparam int D_W       = 28;
  localparam int FULL_W    = PROD_W + D_W;
  localparam int NUM_W     = 57;
  localparam int LOW_W     = 31;
  localparam int MH_W      = NUM_W - 1 - LOW_W;
  localparam int DIV_QBITS = 13;
  localparam int DV_W      = RES_W + DIV_QBITS;
  localparam int SUM_W     = DIV_QBITS + 2;
  localparam int LANES     = 2;

  // Cycles from an accepted transaction to its result strobe
  localparam int RPG_LATENCY = (CORDIC_STAGES + 2) + 2 + (DIV_QBITS + 1) + 1;

  typedef struct packed {
    logic [AZ_W-1:0]  azimuth_count;
    logic [BIN_W-1:0] range_bin;
    logic [PIX_W-1:0] intensity;
  } rpg_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic [PIX_W-1:0] pixel_value;
    logic             in_bounds;
  } rpg_out_t;

  typedef struct packed {
    logic                     valid;
    logic signed [TRIG_W-1:0] cos_q15;
    logic signed [TRIG_W-1:0] sin_q15;
    logic [ODD_W-1:0]         odd_range;
    logic [PIX_W-1:0]         pixel;
  } rpg_trig_t;

  typedef struct packed {
    logic                        valid;
    logic [LANES-1:0][NUM_W-1:0] num;
    logic [PIX_W-1:0]            pixel;
  } rpg_num_t;

  typedef struct packed {
    logic                            valid;
    logic [LANES-1:0][DIV_QBITS-1:0] quo;
    logic [LANES-1:0]                frac;
    logic [LANES-1:0]                neg;
    logic [LANES-1:0]                ovf;
    logic [PIX_W-1:0]                pixel;
  } rpg_quo_t;

  function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
    logic signed [CW-1:0] a;
    case (i)
      0:       a = CW'(843314857);
      1:       a = CW'(497837830);
      2:       a = CW'(263043837);
      3:       a = CW'(133525159);
      4:       a = CW'(67021687);
      5:       a = CW'(33543516);
      6:       a = CW'(16775852);
      7:       a = CW'(8388438);
      8:       a = CW'(4194283);
      9:       a = CW'(2097149);
      10:      a = CW'(1048576);
      11:      a = CW'(524288);
      12:      a = CW'(262144);
      13:      a = CW'(131072);
      14:      a = CW'(65536);
      15:      a = CW'(32768);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rpg_trig.sv
// Azimuth reduction and pipelined CORDIC giving Q1.15 cosine and sine.
// Depends on rpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpg_trig
  import rpg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire rpg_in_t   in_item,
  output rpg_trig_t      trig_o
);

  localparam logic signed [CW-1:0] HALF_LSB = CW'(16384);
  localparam logic signed [CW-1:0] UNIT_Q15 = CW'(32768);

  // Stage 0: fold the count into a quadrant and a Q2.30 residual angle
  logic [AZ_W-1:0]  az_wrap;
  logic [AZ_W-1:0]  az_rem;
  logic [1:0]       quad_nxt;
  logic [31:0]      zprod;
  logic [BIN_W-1:0] bin_sat;

  always_comb begin
    az_wrap = (in_item.azimuth_count >= AZ_W'(AZIMUTH_COUNTS)) ?
              in_item.azimuth_count - AZ_W'(AZIMUTH_COUNTS) : in_item.azimuth_count;
    if (az_wrap >= AZ_W'(3 * QUARTER_COUNTS)) begin
      quad_nxt = 2'd3;
      az_rem   = az_wrap - AZ_W'(3 * QUARTER_COUNTS);
    end else if (az_wrap >= AZ_W'(2 * QUARTER_COUNTS)) begin
      quad_nxt = 2'd2;
      az_rem   = az_wrap - AZ_W'(2 * QUARTER_COUNTS);
    end else if (az_wrap >= AZ_W'(QUARTER_COUNTS)) begin
      quad_nxt = 2'd1;
      az_rem   = az_wrap - AZ_W'(QUARTER_COUNTS);
    end else begin
      quad_nxt = 2'd0;
      az_rem   = az_wrap;
    end
    zprod   = 32'(az_rem[QR_W-1:0]) * 32'(ANGLE_STEP_Q30);
    bin_sat = (32'(in_item.range_bin) >= 32'(RANGE_BINS)) ?
              BIN_W'(RANGE_BINS - 1) : in_item.range_bin;
  end

  logic                 valid_r [0:CORDIC_STAGES];
  logic signed [CW-1:0] x_r     [0:CORDIC_STAGES];
  logic signed [CW-1:0] y_r     [0:CORDIC_STAGES];
  logic signed [CW-1:0] z_r     [0:CORDIC_STAGES];
  logic [1:0]           quad_r  [0:CORDIC_STAGES];
  logic [ODD_W-1:0]     odd_r   [0:CORDIC_STAGES];
  logic [PIX_W-1:0]     pix_r   [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= CW'(CORDIC_GAIN_Q30);
    y_r[0]    <= '0;
    z_r[0]    <= CW'(zprod);
    quad_r[0] <= quad_nxt;
    odd_r[0]  <= {bin_sat, 1'b1};
    pix_r[0]  <= in_item.intensity;
  end

  // CORDIC rotation stages, two micro-rotations each
  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;

    always_comb begin
      logic signed [CW-1:0] cx, cy, cz, sx, sy;
      cx = x_r[s];
      cy = y_r[s];
      cz = z_r[s];
      for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
        sx = cy >>> (s * CORDIC_PER_STAGE + k);
        sy = cx >>> (s * CORDIC_PER_STAGE + k);
        if (!cz[CW-1]) begin
          cx = cx - sx;
          cy = cy + sy;
          cz = cz - atan_q30(s * CORDIC_PER_STAGE + k);
        end else begin
          cx = cx + sx;
          cy = cy - sy;
          cz = cz + atan_q30(s * CORDIC_PER_STAGE + k);
        end
      end
      x_nxt = cx;
      y_nxt = cy;
      z_nxt = cz;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s+1] <= 1'b0;
      end else begin
        valid_r[s+1] <= valid_r[s];
      end
    end

    always_ff @(posedge clk) begin
      x_r[s+1]    <= x_nxt;
      y_r[s+1]    <= y_nxt;
      z_r[s+1]    <= z_nxt;
      quad_r[s+1] <= quad_r[s];
      odd_r[s+1]  <= odd_r[s];
      pix_r[s+1]  <= pix_r[s];
    end
  end

  // Round half up to Q1.15 and clamp to plus or minus one
  function automatic logic signed [TRIG_W-1:0] round_q15(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    t = (v + HALF_LSB) >>> ROUND_SHIFT;
    if (t > UNIT_Q15) begin
      t = UNIT_Q15;
    end else if (t < -UNIT_Q15) begin
      t = -UNIT_Q15;
    end
    return t[TRIG_W-1:0];
  endfunction

  logic signed [TRIG_W-1:0] cq, sq, cos_nxt, sin_nxt;

  always_comb begin
    cq = round_q15(x_r[CORDIC_STAGES]);
    sq = round_q15(y_r[CORDIC_STAGES]);
    case (quad_r[CORDIC_STAGES])
      2'd0: begin
        cos_nxt = cq;
        sin_nxt = sq;
      end
      2'd1: begin
        cos_nxt = -sq;
        sin_nxt = cq;
      end
      2'd2: begin
        cos_nxt = -cq;
        sin_nxt = -sq;
      end
      default: begin
        cos_nxt = sq;
        sin_nxt = -cq;
      end
    endcase
  end

  logic                     out_valid_r;
  logic signed [TRIG_W-1:0] cos_r, sin_r;
  logic [ODD_W-1:0]         out_odd_r;
  logic [PIX_W-1:0]         out_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_r[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    cos_r     <= cos_nxt;
    sin_r     <= sin_nxt;
    out_odd_r <= odd_r[CORDIC_STAGES];
    out_pix_r <= pix_r[CORDIC_STAGES];
  end

  assign trig_o = '{valid: out_valid_r, cos_q15: cos_r, sin_q15: sin_r,
                    odd_range: out_odd_r, pixel: out_pix_r};

endmodule

`default_nettype wire

// File: hw/rtl/rpg_scale.sv
// Two-stage multiplier: odd range count times trig, then times the half-bin step.
// Depends on rpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpg_scale
  import rpg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire rpg_trig_t trig_i,
  output rpg_num_t       num_o
);

  localparam logic signed [D_W-1:0] DIST_STEP = D_W'(HALF_BIN_STEP_Q32);

  logic                     v1_r, v2_r;
  logic signed [PROD_W-1:0] pc_r, ps_r;
  logic [PIX_W-1:0]         pix1_r, pix2_r;
  logic signed [PROD_W-1:0] pc_nxt, ps_nxt;
  logic signed [FULL_W-1:0] fc_nxt, fs_nxt;
  logic [NUM_W-1:0]         nc_r, ns_r;

  always_comb begin
    pc_nxt = signed'({1'b0, trig_i.odd_range}) * trig_i.cos_q15;
    ps_nxt = signed'({1'b0, trig_i.odd_range}) * trig_i.sin_q15;
    fc_nxt = pc_r * DIST_STEP;
    fs_nxt = ps_r * DIST_STEP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= trig_i.valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    pc_r   <= pc_nxt;
    ps_r   <= ps_nxt;
    pix1_r <= trig_i.pixel;
    nc_r   <= fc_nxt[NUM_W-1:0];
    ns_r   <= fs_nxt[NUM_W-1:0];
    pix2_r <= pix1_r;
  end

  assign num_o.valid  = v2_r;
  assign num_o.num[0] = nc_r;
  assign num_o.num[1] = ns_r;
  assign num_o.pixel  = pix2_r;

endmodule

`default_nettype wire

// File: hw/rtl/rpg_div.sv
// Pipelined restoring divider, one quotient bit per stage, for row and column lanes.
// Divides |num| by resolution * 2^31 with a saturation flag. Depends on rpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpg_div
  import rpg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [RES_W-1:0] res,
  input  wire rpg_num_t         num_i,
  output rpg_quo_t              quo_o
);

  logic             valid_r [0:DIV_QBITS];
  logic [PIX_W-1:0] pix_r   [0:DIV_QBITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= num_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    pix_r[0] <= num_i.pixel;
  end

  for (genvar j = 0; j < DIV_QBITS; j++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j+1] <= 1'b0;
      end else begin
        valid_r[j+1] <= valid_r[j];
      end
    end

    always_ff @(posedge clk) begin
      pix_r[j+1] <= pix_r[j];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [MH_W-1:0]      rem_r   [0:DIV_QBITS];
    logic [DIV_QBITS-1:0] quo_r   [0:DIV_QBITS];
    logic                 lo_nz_r [0:DIV_QBITS];
    logic                 neg_r   [0:DIV_QBITS];
    logic                 ovf_r   [0:DIV_QBITS];

    logic signed [NUM_W-1:0] numv;
    logic [NUM_W-1:0]        mag;
    logic                    neg_nxt, ovf_nxt;

    // Split the magnitude: high part is divided, low bits only feed the fraction flag
    always_comb begin
      numv    = signed'(num_i.num[l]);
      neg_nxt = numv[NUM_W-1];
      mag     = neg_nxt ? NUM_W'(-numv) : NUM_W'(numv);
      ovf_nxt = DV_W'(mag[NUM_W-2:LOW_W]) >= {res, {DIV_QBITS{1'b0}}};
    end

    always_ff @(posedge clk) begin
      rem_r[0]   <= mag[NUM_W-2:LOW_W];
      quo_r[0]   <= '0;
      lo_nz_r[0] <= |mag[LOW_W-1:0];
      neg_r[0]   <= neg_nxt;
      ovf_r[0]   <= ovf_nxt;
    end

    for (genvar j = 0; j < DIV_QBITS; j++) begin : g_step
      localparam int BIT = DIV_QBITS - 1 - j;
      logic [DV_W-1:0]      sh, remx;
      logic [MH_W-1:0]      rem_nxt;
      logic [DIV_QBITS-1:0] quo_nxt;

      always_comb begin
        sh      = DV_W'(res) << BIT;
        remx    = DV_W'(rem_r[j]);
        rem_nxt = rem_r[j];
        quo_nxt = quo_r[j];
        if (remx >= sh) begin
          rem_nxt      = MH_W'(remx - sh);
          quo_nxt[BIT] = 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        rem_r[j+1]   <= rem_nxt;
        quo_r[j+1]   <= quo_nxt;
        lo_nz_r[j+1] <= lo_nz_r[j];
        neg_r[j+1]   <= neg_r[j];
        ovf_r[j+1]   <= ovf_r[j];
      end
    end

    assign quo_o.quo[l]  = quo_r[DIV_QBITS];
    assign quo_o.frac[l] = lo_nz_r[DIV_QBITS] | (rem_r[DIV_QBITS] != '0);
    assign quo_o.neg[l]  = neg_r[DIV_QBITS];
    assign quo_o.ovf[l]  = ovf_r[DIV_QBITS];
  end

  assign quo_o.valid = valid_r[DIV_QBITS];
  assign quo_o.pixel = pix_r[DIV_QBITS];

endmodule

`default_nettype wire

// File: hw/rtl/radar_polar_to_grid_pixel.sv
// Top level of the radar polar-to-grid pixel converter.
// Instantiates rpg_trig, rpg_scale and rpg_div; depends on rpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Converts one radar target (azimuth count, range bin, intensity) into one grid
// pixel: row, column, intensity and an in-bounds flag.
//
// Input channel: drive in_data and raise start. A transaction is taken at every
// rising edge where start is high and busy is low. busy is low whenever reset is
// released, so one target can enter on every cycle.
// Result channel: out_valid strobes for one cycle with out_data. The receiver
// cannot stall; results follow inputs in order.
// The path runs through the azimuth fold and the 8-stage CORDIC (two
// micro-rotations per stage) with rounding, the two multipliers, the divider
// (one quotient bit per stage) and index placement.
// Throughput: one transaction per cycle, set by the fully pipelined datapath.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 grid_rows,
// 1 grid_cols, 2 metres_per_pixel_q16); other indexes are ignored. Write only
// while the pipeline is empty.
// Reset (synchronous, rst_n low) clears all valid bits and loads the register
// defaults: 512 rows, 512 columns, 0.25 m per pixel.
module radar_polar_to_grid_pixel
  import rpg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire rpg_in_t          in_data,
  output logic                  out_valid,
  output rpg_out_t              out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [RES_W-1:0] cfg_data
);

  // Configuration registers
  logic [DIM_W-1:0] grid_rows_r, grid_cols_r;
  logic [RES_W-1:0] res_q16_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= DIM_W'(512);
      grid_cols_r <= DIM_W'(512);
      res_q16_r   <= RES_W'(16384);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_ROWS: grid_rows_r <= cfg_data[DIM_W-1:0];
        CFG_GRID_COLS: grid_cols_r <= cfg_data[DIM_W-1:0];
        CFG_RES_Q16:   res_q16_r   <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Effective values: saturate dimensions, treat zero resolution as one LSB
  logic [DIM_W-1:0] dim [LANES];
  logic [RES_W-1:0] res_eff;

  always_comb begin
    dim[0]  = (grid_rows_r > DIM_W'(MAX_GRID_DIM)) ? DIM_W'(MAX_GRID_DIM) : grid_rows_r;
    dim[1]  = (grid_cols_r > DIM_W'(MAX_GRID_DIM)) ? DIM_W'(MAX_GRID_DIM) : grid_cols_r;
    res_eff = (res_q16_r == '0) ? RES_W'(1) : res_q16_r;
  end

  // Hold off transactions only while in reset
  assign busy = ~rst_n;

  rpg_trig_t trig;
  rpg_num_t  num;
  rpg_quo_t  quo;

  rpg_trig u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(start & ~busy),
    .in_item (in_data),
    .trig_o  (trig)
  );

  rpg_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .trig_i(trig),
    .num_o (num)
  );

  rpg_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .res  (res_eff),
    .num_i(num),
    .quo_o(quo)
  );

  // Placement: floor quotient plus half dimension, then the bounds test
  logic [LANES-1:0]            lane_ok;
  logic [LANES-1:0][IDX_W-1:0] lane_idx;

  for (genvar l = 0; l < LANES; l++) begin : g_place
    logic signed [SUM_W-1:0] qs, f, half, dim_s, sum;

    always_comb begin
      qs    = signed'(SUM_W'(quo.quo[l]));
      f     = quo.neg[l] ? (-qs - SUM_W'(quo.frac[l])) : qs;
      half  = signed'(SUM_W'(dim[l] >> 1));
      dim_s = signed'(SUM_W'(dim[l]));
      sum   = f + half;
      // A sum just below zero truncates toward zero and lands on index zero
      lane_ok[l] = !quo.ovf[l] &&
                   ((!sum[SUM_W-1] && (sum < dim_s)) ||
                    ((sum == {SUM_W{1'b1}}) && quo.frac[l] && (dim[l] != '0)));
      lane_idx[l] = sum[SUM_W-1] ? '0 : sum[IDX_W-1:0];
    end
  end

  logic     out_valid_r;
  rpg_out_t out_r;
  rpg_out_t out_nxt;

  always_comb begin
    out_nxt.in_bounds   = &lane_ok;
    out_nxt.row_index   = out_nxt.in_bounds ? lane_idx[0] : '0;
    out_nxt.col_index   = out_nxt.in_bounds ? lane_idx[1] : '0;
    out_nxt.pixel_value = out_nxt.in_bounds ? quo.pixel : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= quo.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: hw/rtl/rpg_checker.sv
// Port-level checker for radar_polar_to_grid_pixel, bound to the top level.
// Depends on rpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpg_checker
  import rpg_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire rpg_in_t  in_data,
  input wire logic     out_valid,
  input wire rpg_out_t out_data
);

  logic accept;
  assign accept = start & ~busy;

  // Every accepted transaction yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##RPG_LATENCY out_valid)
    else $error("accepted transaction produced no result");

  // No result without a transaction accepted at the matching cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, RPG_LATENCY))
    else $error("result strobe without a matching transaction");

  // A written pixel carries the intensity of its own transaction
  a_pixel_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.in_bounds) |->
      (out_data.pixel_value == $past(in_data.intensity, RPG_LATENCY)))
    else $error("pixel value does not match its transaction");

  // Dropped targets report all-zero payload
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.in_bounds) |->
      (out_data.row_index == '0 && out_data.col_index == '0 &&
       out_data.pixel_value == '0))
    else $error("out-of-bounds result has nonzero fields");

endmodule

bind radar_polar_to_grid_pixel rpg_checker u_rpg_checker (.*);

`default_nettype wire
